// ===== hdl/tbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, constants and helpers of the terminal byte sanitizer.
// ----------------------------------------------------------------------------
package tbs_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_MODE_FLAGS     = 2'd0;
  localparam logic [1:0] REG_NEWLINE_LENGTH = 2'd1;
  localparam logic [1:0] REG_NEWLINE_BYTES  = 2'd2;

  // Mode flag bit positions
  localparam int F_LF     = 0;
  localparam int F_CUSTOM = 1;
  localparam int F_DELNL  = 2;
  localparam int F_INVHEX = 3;
  localparam int F_DELINV = 4;
  localparam int F_NOBS   = 5;
  localparam int F_KEEP15 = 6;
  localparam int F_NONUL  = 7;
  localparam int F_ALLHEX = 8;

  // Longest custom newline and the cap applied to newline_length
  localparam int          NEWLINE_MAX = 4;
  localparam int          NL_CAP_INT  = (NEWLINE_MAX < 4) ? NEWLINE_MAX : 4;
  localparam logic [2:0]  NL_CAP      = 3'(NL_CAP_INT);

  // Byte constants
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LO15  = 8'h01;
  localparam logic [7:0] CH_HI15  = 8'h05;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  // Reset values of the registers
  localparam logic [8:0]  MODE_RST  = 9'h000;
  localparam logic [2:0]  NLLEN_RST = 3'd2;
  localparam logic [31:0] NLBYT_RST = 32'h0000_0A0D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [8:0]  mode_flags;
    logic [2:0]  newline_length;
    logic [31:0] newline_bytes;
  } cfg_t;

  // Up to four output bytes produced by one item, byte 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } bundle_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v};
    return (v < 4'd10) ? (8'h30 + w) : (8'h37 + w);
  endfunction

endpackage

// ===== hdl/tbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_front
// Classifies each accepted item and expands it into a bundle of output bytes.
// ----------------------------------------------------------------------------
module tbs_front import tbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     accept,
  input  in_item_t item,
  output logic     push,
  output bundle_t  bundle
);

  logic [7:0] prev_byte_r, prev_byte_nxt;
  logic       prev_drop_r, prev_drop_nxt;

  logic [7:0] c;
  logic       is_nl, prev_nl, handled, dropped;
  logic [2:0] nl_len;
  logic [8:0] m;

  assign c = item.in_byte;
  assign m = cfg.mode_flags;
  assign is_nl   = (c == CH_LF) || (c == CH_CR);
  assign prev_nl = (prev_byte_r == CH_LF) || (prev_byte_r == CH_CR);
  assign nl_len  = (cfg.newline_length > NL_CAP) ? NL_CAP : cfg.newline_length;

  always_comb begin
    bundle       = '0;
    handled      = 1'b0;
    dropped      = 1'b0;
    if (m[F_ALLHEX]) begin
      bundle.bytes[0] = hex_digit(c[7:4]);
      bundle.bytes[1] = hex_digit(c[3:0]);
      bundle.bytes[2] = CH_SPACE;
      bundle.count    = 3'd3;
      handled         = 1'b1;
    end else if (is_nl) begin
      handled = 1'b1;
      if (m[F_DELNL]) begin
        bundle.count = 3'd0;
      end else if ((m[F_LF] || m[F_CUSTOM]) && prev_nl && (prev_byte_r != c) &&
                   !prev_drop_r) begin
        dropped = 1'b1;
      end else if (m[F_LF]) begin
        bundle.bytes[0] = CH_LF;
        bundle.count    = 3'd1;
      end else if (m[F_CUSTOM]) begin
        bundle.bytes = cfg.newline_bytes;
        bundle.count = nl_len;
      end else begin
        bundle.bytes[0] = c;
        bundle.count    = 3'd1;
      end
    end else if (c == CH_BS) begin
      handled = m[F_NOBS];
    end else if (c == CH_NUL) begin
      handled = m[F_NONUL];
    end else if (((c >= CH_SPACE) && (c <= CH_TILDE)) || (c == CH_TAB)) begin
      bundle.bytes[0] = c;
      bundle.count    = 3'd1;
      handled         = 1'b1;
    end else if ((c >= CH_LO15) && (c <= CH_HI15) && m[F_KEEP15]) begin
      bundle.bytes[0] = c;
      bundle.count    = 3'd1;
      handled         = 1'b1;
    end

    if (!handled) begin
      if (m[F_DELINV]) begin
        bundle.count = 3'd0;
      end else if (m[F_INVHEX]) begin
        bundle.bytes[0] = CH_LBRK;
        bundle.bytes[1] = hex_digit(c[7:4]);
        bundle.bytes[2] = hex_digit(c[3:0]);
        bundle.bytes[3] = CH_RBRK;
        bundle.count    = 3'd4;
      end else begin
        bundle.bytes[0] = c;
        bundle.count    = 3'd1;
      end
    end
  end

  assign push = accept && (bundle.count != 3'd0);

  // History clears after the last item of a string
  always_comb begin
    prev_byte_nxt = prev_byte_r;
    prev_drop_nxt = prev_drop_r;
    if (accept) begin
      if (item.end_of_string) begin
        prev_byte_nxt = 8'h00;
        prev_drop_nxt = 1'b0;
      end else begin
        prev_byte_nxt = c;
        prev_drop_nxt = dropped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r <= 8'h00;
      prev_drop_r <= 1'b0;
    end else begin
      prev_byte_r <= prev_byte_nxt;
      prev_drop_r <= prev_drop_nxt;
    end
  end

endmodule

// ===== hdl/tbs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_queue
// Short register queue of byte bundles between the front and back parts.
// ----------------------------------------------------------------------------
module tbs_queue import tbs_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bundle_t            store_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_data  = store_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/tbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_back
// Serializes the head bundle into out_item_r, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module tbs_back import tbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  bundle_t   head_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  logic        load, is_last;

  // Load when the output register is empty or is being taken this cycle
  assign load    = head_valid && (!out_valid_r || !out_stall);
  assign is_last = ({1'b0, idx_r} == (head_data.count - 3'd1));
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.out_byte    <= head_data.bytes[idx_r];
      out_item_r.last_of_run <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/terminal_byte_sanitizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_byte_sanitizer_core
// Cleans a received byte stream: hex dump, line ending rewrite, removal or
// bracketing of non-printable bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_item carries one received byte and
//   an end-of-string mark per item. Output channel out_valid / out_stall /
//   out_item carries zero to four bytes per input item; last_of_run marks
//   the final byte of each input item. Items that expand to nothing emit no
//   output at all.
//   Each bundle is registered in the queue before its bytes reach the output.
//   Throughput: one input item per cycle for single-byte results while
//   out_stall is low; an item that expands to more than one byte is limited by
//   the single output register that the serializer fills one byte a cycle.
//   A queue of QUEUE_DEPTH bundles decouples the classifier from the
//   serializer; in_stall rises only when that queue is full.
//   Reset (rst_n low, synchronous) empties the queue and output register,
//   clears the byte history and loads the register defaults (mode 0, CR/LF
//   custom newline of length 2).
//   While out_stall is high the output item holds; the queue keeps taking
//   items until it fills.
//   Write configuration through cfg_we / cfg_index / cfg_data only while
//   the block is idle.
// ----------------------------------------------------------------------------
module terminal_byte_sanitizer_core import tbs_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  logic    in_accept;
  logic    push, full, pop, head_valid;
  bundle_t push_data, head_data;

  // Register file: take each write by index, ignore unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE_FLAGS:     cfg_nxt.mode_flags     = cfg_data[8:0];
        REG_NEWLINE_LENGTH: cfg_nxt.newline_length = cfg_data[2:0];
        REG_NEWLINE_BYTES:  cfg_nxt.newline_bytes  = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_flags     <= MODE_RST;
      cfg_r.newline_length <= NLLEN_RST;
      cfg_r.newline_bytes  <= NLBYT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold off the sender only when the bundle queue has no room
  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  tbs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_accept),
    .item   (in_item),
    .push   (push),
    .bundle (push_data)
  );

  tbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  tbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== hdl/tbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks of the terminal byte sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker import tbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // Reset empties the output and the queue
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // With no output pending the queue cannot be full
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // The queue fills only by taking an item while an output byte is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall && out_valid))
    else $error("input stall without a taken item and a pending output");

endmodule

bind terminal_byte_sanitizer_core tbs_checker u_tbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== verif/tbs_sanitize_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_sanitize_checker
// Watches both channels and the register port of the sanitizer, predicts
// the bytes each item must produce and compares them in order.
// ----------------------------------------------------------------------------
module tbs_sanitize_checker import tbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          pending,
  output int          fail_count,
  output int          bytes_checked
);

  localparam int MAX_REPORTS = 20;

  out_item_t   expected_bytes[$];
  logic [8:0]  mode_reg;
  logic [2:0]  nl_len_reg;
  logic [31:0] nl_bytes_reg;
  logic [7:0]  hist_byte;
  logic        hist_pair_dropped;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? {4'h3, nib} : 8'h41 + {4'h0, nib - 4'd10};
  endfunction

  // Work out the bytes one item expands to and queue them
  task automatic predict_sanitized(input in_item_t item);
    logic [3:0][7:0] emit;
    int              count;
    int              run_len;
    int              idx;
    logic [7:0]      ch;
    logic [7:0]      prior;
    logic            claimed;
    logic            pair_dropped;
    out_item_t       exp_item;
    ch = item.in_byte;
    prior = hist_byte;
    emit = '0;
    count = 0;
    claimed = 1'b0;
    pair_dropped = 1'b0;
    if (mode_reg[F_ALLHEX]) begin
      emit[0] = hex_char(ch[7:4]);
      emit[1] = hex_char(ch[3:0]);
      emit[2] = CH_SPACE;
      count = 3;
      claimed = 1'b1;
    end else if (ch == CH_LF || ch == CH_CR) begin
      claimed = 1'b1;
      if (mode_reg[F_DELNL]) begin
        count = 0;
      end else if ((mode_reg[F_LF] || mode_reg[F_CUSTOM]) &&
                   (prior == CH_LF || prior == CH_CR) && prior != ch &&
                   !hist_pair_dropped) begin
        pair_dropped = 1'b1;
      end else if (mode_reg[F_LF]) begin
        emit[0] = CH_LF;
        count = 1;
      end else if (mode_reg[F_CUSTOM]) begin
        run_len = nl_len_reg;
        if (run_len > NEWLINE_MAX) run_len = NEWLINE_MAX;
        if (run_len > 4) run_len = 4;
        for (idx = 0; idx < run_len; idx++) emit[idx] = nl_bytes_reg[8*idx +: 8];
        count = run_len;
      end else begin
        emit[0] = ch;
        count = 1;
      end
    end else if (ch == CH_BS) begin
      claimed = mode_reg[F_NOBS];
    end else if (ch == CH_NUL) begin
      claimed = mode_reg[F_NONUL];
    end else if ((ch >= CH_SPACE && ch <= CH_TILDE) || ch == CH_TAB) begin
      emit[0] = ch;
      count = 1;
      claimed = 1'b1;
    end else if (ch >= CH_LO15 && ch <= CH_HI15 && mode_reg[F_KEEP15]) begin
      emit[0] = ch;
      count = 1;
      claimed = 1'b1;
    end

    if (!claimed && !mode_reg[F_DELINV]) begin
      if (mode_reg[F_INVHEX]) begin
        emit[0] = CH_LBRK;
        emit[1] = hex_char(ch[7:4]);
        emit[2] = hex_char(ch[3:0]);
        emit[3] = CH_RBRK;
        count = 4;
      end else begin
        emit[0] = ch;
        count = 1;
      end
    end

    for (idx = 0; idx < count; idx++) begin
      exp_item.out_byte = emit[idx];
      exp_item.last_of_run = (idx == count - 1);
      expected_bytes.push_back(exp_item);
    end

    if (item.end_of_string) begin
      hist_byte = 8'h00;
      hist_pair_dropped = 1'b0;
    end else begin
      hist_byte = ch;
      hist_pair_dropped = pair_dropped;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      mode_reg = MODE_RST;
      nl_len_reg = NLLEN_RST;
      nl_bytes_reg = NLBYT_RST;
      hist_byte = 8'h00;
      hist_pair_dropped = 1'b0;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected output, expected none, got byte %h last %b",
                     $time, out_item.out_byte, out_item.last_of_run);
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_item.out_byte !== want.out_byte) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: out_byte mismatch, expected %h, got %h",
                       $time, want.out_byte, out_item.out_byte);
          end
          if (out_item.last_of_run !== want.last_of_run) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: last_of_run mismatch, expected %b, got %b",
                       $time, want.last_of_run, out_item.last_of_run);
          end
        end
      end
      if (in_valid && !in_stall) predict_sanitized(in_item);
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE_FLAGS:     mode_reg = cfg_data[8:0];
          REG_NEWLINE_LENGTH: nl_len_reg = cfg_data[2:0];
          REG_NEWLINE_BYTES:  nl_bytes_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== verif/tb_terminal_byte_sanitizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_byte_sanitizer_core
// Drives byte streams through the sanitizer under a series of register
// settings, with random gaps and stalls on both channels; the checker
// beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module tb_terminal_byte_sanitizer_core;
  import tbs_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int TIMEOUT_CYCLES  = 400_000;
  localparam int DRAIN_CYCLES    = 16;   // queue depth plus output register, with margin
  localparam int SQUEEZE_CYCLES  = 80;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 43;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int pending;
  int fail_count;
  int bytes_checked;
  int items_sent;
  int configs_loaded;

  // Flags shared between the sender and the receiver processes
  logic no_idle;
  logic squeeze_req;
  logic squeeze_done;

  terminal_byte_sanitizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tbs_sanitize_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .fail_count    (fail_count),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  // Idle length: mostly none, sometimes short, rarely a long gap; none while no_idle
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Console-like traffic: text, line endings, low controls and raw noise
  function automatic logic [7:0] stream_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 8'($urandom_range(32'h20, 32'h7E));
    if (roll < 55) return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
    if (roll < 63) return 8'($urandom_range(1, 5));
    if (roll < 71) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_NUL;
    if (roll < 80) return 8'($urandom_range(0, 31));
    return 8'($urandom);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= in_item_t'{in_byte: b, end_of_string: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, wait for every expected byte, then let trailing
  // zero-output items clear the block
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges; only call when idle
  task automatic load_config(input logic [8:0] mode, input logic [2:0] nl_len,
                             input logic [31:0] nl_bytes);
    cfg_we <= 1'b1;
    cfg_index <= REG_MODE_FLAGS;
    cfg_data <= {23'd0, mode};
    @(posedge clk);
    cfg_index <= REG_NEWLINE_LENGTH;
    cfg_data <= {29'd0, nl_len};
    @(posedge clk);
    cfg_index <= REG_NEWLINE_BYTES;
    cfg_data <= nl_bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    configs_loaded++;
  endtask

  // Receiver: random stalls, plus one long hold-off so the queue fills up
  initial begin : receiver
    int span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        span = idle_span();
        if (span == 0) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (span) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int          p;
    int          n;
    logic [8:0]  mode;
    logic [2:0]  nl_len;
    logic [31:0] nl_bytes;

    no_idle = 1'b0;
    squeeze_req = 1'b0;
    squeeze_done = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODE_FLAGS;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset mode: everything passes through raw, field extremes included
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_TILDE, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(CH_CR, 1'b1);
    settle();

    // LF beats the custom newline; a collapsed pair does not collapse again;
    // history clears after end of string; backspace and null go to [XX]
    mode = '0;
    mode[F_LF] = 1'b1;
    mode[F_CUSTOM] = 1'b1;
    mode[F_INVHEX] = 1'b1;
    mode[F_KEEP15] = 1'b1;
    load_config(mode, 3'd4, 32'h0000_0000);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b1);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(8'h02, 1'b1);
    settle();

    // Custom newline with saturated length; delete beats [XX];
    // backspace and null removal
    mode = '0;
    mode[F_CUSTOM] = 1'b1;
    mode[F_DELINV] = 1'b1;
    mode[F_INVHEX] = 1'b1;
    mode[F_NOBS] = 1'b1;
    mode[F_NONUL] = 1'b1;
    load_config(mode, 3'd7, 32'h00FF_0A0D);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h05, 1'b1);
    settle();

    // Hex dump overrides every other option
    load_config(9'h1FF, 3'd0, 32'hFFFF_FFFF);
    send_byte(CH_CR, 1'b0);
    send_byte(8'hA5, 1'b1);
    settle();

    // Deleting line endings beats pair dropping and LF
    mode = '0;
    mode[F_DELNL] = 1'b1;
    mode[F_LF] = 1'b1;
    load_config(mode, NLLEN_RST, NLBYT_RST);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b1);
    settle();

    // Random streams, one register setting per phase
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          mode = 9'h1FF;
          nl_len = 3'd7;
          nl_bytes = 32'hFFFF_FFFF;
        end
        1: begin
          mode = 9'h000;
          nl_len = 3'd0;
          nl_bytes = 32'h0000_0000;
        end
        2: begin
          // Multi-byte expansions while the receiver holds off
          mode = '0;
          mode[F_CUSTOM] = 1'b1;
          mode[F_INVHEX] = 1'b1;
          nl_len = 3'd4;
          nl_bytes = $urandom;
        end
        3: begin
          // Custom newline of length zero emits nothing
          mode = 9'($urandom);
          mode[F_CUSTOM] = 1'b1;
          mode[F_LF] = 1'b0;
          mode[F_DELNL] = 1'b0;
          mode[F_ALLHEX] = 1'b0;
          nl_len = 3'd0;
          nl_bytes = $urandom;
        end
        default: begin
          mode = 9'($urandom);
          if ($urandom_range(0, 5) != 0) mode[F_ALLHEX] = 1'b0;
          nl_len = 3'($urandom_range(0, 7));
          nl_bytes = $urandom;
        end
      endcase
      load_config(mode, nl_len, nl_bytes);
      if (p == 2) squeeze_req = 1'b1;
      no_idle = (p == 4);
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        send_byte(stream_byte(), $urandom_range(0, 11) == 0);
      settle();
      no_idle = 1'b0;
    end

    $display("Sanitizer run: %0d items through %0d register settings plus reset mode,",
             items_sent, configs_loaded);
    $display("  %0d output bytes compared, %0d mismatches", bytes_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tbs_pkg.sv
hdl/tbs_front.sv
hdl/tbs_queue.sv
hdl/tbs_back.sv
hdl/terminal_byte_sanitizer_core.sv
hdl/tbs_checker.sv
verif/tbs_sanitize_checker.sv
verif/tb_terminal_byte_sanitizer_core.sv
